@@ sv/pwdp_pkg.sv @@
// ----------------------------------------------------------------------------
// pwdp_pkg
// Shared constants and helpers for the power-of-two weight dot product unit.
// ----------------------------------------------------------------------------
package pwdp_pkg;

    localparam int unsigned DataWidth  = 32;
    localparam int unsigned CodeWidth  = 8;
    localparam int unsigned ExpShift   = 23;
    localparam logic [31:0] SignMask   = 32'h8000_0000;
    localparam logic [31:0] AbsMask    = 32'h7FFF_FFFF;
    localparam logic [31:0] InfBits    = 32'h7F80_0000;
    localparam logic [31:0] CanonNan   = 32'h7FC0_0000;
    localparam logic signed [7:0] NegLimit  = 8'sd31;
    localparam logic signed [7:0] NegOffset = 8'sd32;

    // Scale the activation by the weight's power of two, in the bit domain.
    function automatic logic [31:0] make_term(input logic [31:0] act,
                                              input logic [7:0] code);
        logic signed [7:0] s;
        logic              neg;
        logic [31:0]       shifted;
        logic [31:0]       res;
        s   = signed'(code);
        neg = (s > NegLimit);
        if (neg) begin
            s = s - NegOffset;
        end
        shifted = {{(32 - ExpShift - 8){s[7]}}, s, {ExpShift{1'b0}}};
        res = act;
        if ((act & AbsMask) != InfBits) begin
            res = act + shifted;
        end
        if (neg) begin
            res = res ^ SignMask;
        end
        return res;
    endfunction

endpackage

@@ sv/pwdp_fadd.sv @@
// ----------------------------------------------------------------------------
// pwdp_fadd
// Combinational single-precision adder, round to nearest even, canonical NaN.
// ----------------------------------------------------------------------------
module pwdp_fadd
    import pwdp_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] sum
);

    logic        a_nan, b_nan, a_inf, b_inf;
    logic [31:0] big, sml;
    logic [7:0]  eb, es;
    logic [26:0] mb, ms, ms_sh;
    logic [7:0]  diff;
    logic        sticky;
    logic        sub;
    logic [27:0] raw;
    logic [4:0]  lz;
    logic [27:0] norm;
    logic signed [9:0] exp_n;
    logic [27:0] mant_sh;
    logic [24:0] rnd;
    logic [8:0]  ef;
    logic        lsb, g, rs;
    logic        found;

    always_comb begin
        a_nan = (a & AbsMask) > InfBits;
        b_nan = (b & AbsMask) > InfBits;
        a_inf = (a & AbsMask) == InfBits;
        b_inf = (b & AbsMask) == InfBits;
        if ((a & AbsMask) >= (b & AbsMask)) begin
            big = a; sml = b;
        end else begin
            big = b; sml = a;
        end
        eb = big[30:23];
        es = sml[30:23];
        // mantissa with hidden bit, plus guard, round and sticky bits
        mb = {(eb != 8'd0), big[22:0], 3'b000};
        ms = {(es != 8'd0), sml[22:0], 3'b000};
        diff = (eb == 8'd0 ? 8'd1 : eb) - (es == 8'd0 ? 8'd1 : es);
        if (diff >= 8'd27) begin
            ms_sh  = 27'd0;
            sticky = (ms != 27'd0);
        end else begin
            ms_sh  = ms >> diff;
            sticky = ((ms & ((27'd1 << diff) - 27'd1)) != 27'd0);
        end
        ms_sh[0] = ms_sh[0] | sticky;
        sub = big[31] ^ sml[31];
        raw = sub ? ({1'b0, mb} - {1'b0, ms_sh}) : ({1'b0, mb} + {1'b0, ms_sh});
        // leading zero count over 28 bits
        lz = 5'd0;
        found = 1'b0;
        for (int i = 27; i >= 0; i--) begin
            if (!found && raw[i]) begin
                found = 1'b1;
                lz = 5'(27 - i);
            end
        end
        exp_n = signed'({2'b00, (eb == 8'd0 ? 8'd1 : eb)}) + 10'sd1 - signed'({5'd0, lz});
        if (exp_n < 10'sd1) begin
            // subnormal result: shift only as far as exponent allows
            mant_sh = raw << (lz - 5'(1 - exp_n));
            exp_n = 10'sd0;
        end else begin
            mant_sh = raw << lz;
        end
        norm = mant_sh;
        lsb = norm[4];
        g   = norm[3];
        rs  = |norm[2:0];
        rnd = {1'b0, norm[27:4]} + {24'd0, (g & (rs | lsb))};
        ef  = exp_n[8:0];
        if (rnd[24]) begin
            ef = ef + 9'd1;
            rnd = rnd >> 1;
        end else if (exp_n == 10'sd0 && rnd[23]) begin
            ef = 9'd1;
        end
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            sum = CanonNan;
        end else if (a_inf) begin
            sum = a;
        end else if (b_inf) begin
            sum = b;
        end else if (raw == 28'd0) begin
            sum = {a[31] & b[31], 31'd0};
        end else if (ef >= 9'd255) begin
            sum = {big[31], InfBits[30:0]};
        end else begin
            sum = {big[31], ef[7:0], rnd[22:0]};
        end
    end

endmodule

@@ sv/pot_weight_dot_product_unit.sv @@
// ----------------------------------------------------------------------------
// pot_weight_dot_product_unit
// Streams activation/weight pairs and accumulates a float dot product.
// ----------------------------------------------------------------------------
// The final input transfer is captured in the input register stage; its sum
// then lands in the result register and raises m_valid. Throughput: one
// transfer per cycle unless a full output stalls; the float adder sets the cycle.
// Reset (aresetn low, synchronous) clears the accumulator to +0 and both
// valid flags.
module pot_weight_dot_product_unit
    import pwdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_act_bits,
    input  logic [7:0]  s_weight_code,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dot_sum
);

    // Input register stage holds the scaled term.
    logic        in_valid_reg;
    logic [31:0] term_reg;
    logic        last_reg;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] sum;
    logic        out_valid_reg;
    logic [31:0] out_reg;
    logic        advance;

    pwdp_fadd u_fadd (.a(acc_reg), .b(term_reg), .sum(sum));

    // The stage advances unless a final sum must land on a full output.
    assign advance = !(in_valid_reg && last_reg && out_valid_reg && !m_ready);
    assign s_ready = advance;
    assign acc_next = (in_valid_reg && advance) ? (last_reg ? 32'd0 : sum) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 32'd0;
        end else begin
            acc_reg <= acc_next;
            if (advance) begin
                in_valid_reg <= s_valid;
                term_reg     <= make_term(s_act_bits, s_weight_code);
                last_reg     <= s_last;
            end
            if (in_valid_reg && last_reg && advance) begin
                out_valid_reg <= 1'b1;
                out_reg       <= sum;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_dot_sum = out_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result lost while stalled");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && last_reg && advance |=> acc_reg == 32'd0)
        else $error("accumulator not cleared after last");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |-> out_valid_reg && in_valid_reg)
        else $error("spurious stall");

endmodule

@@ bench/pwdp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwdp_checker
// Watches both channels of the dot product unit, predicts every sum from the
// accepted input transfers and compares it with the result transfers.
// ----------------------------------------------------------------------------
module pwdp_checker
    import pwdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_act_bits,
    input  logic [7:0]  s_weight_code,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_dot_sum,
    output int          fail_count,
    output int          pending
);

    logic [31:0] running_sum;
    logic [31:0] sum_queue[$];

    // Weight code applied to the activation in the bit domain.
    function automatic logic [31:0] scaled_term(logic [31:0] act, logic [7:0] code);
        logic signed [7:0] shift;
        logic              negate;
        logic [31:0]       r;
        shift  = signed'(code);
        negate = shift > NegLimit;
        if (negate) begin
            shift = shift - NegOffset;
        end
        r = act;
        if ((act & AbsMask) != InfBits) begin
            r = act + {shift[7], shift, 23'b0};
        end
        if (negate) begin
            r = r ^ SignMask;
        end
        return r;
    endfunction

    // Single precision addition, round to nearest even, NaNs made canonical.
    function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
        logic [31:0] x, y, mx, my, m, r;
        int          ex, ey, d, e, ef;
        logic        up;
        if ((a & AbsMask) > InfBits || (b & AbsMask) > InfBits) return CanonNan;
        if ((a & AbsMask) == InfBits) begin
            if ((b & AbsMask) == InfBits && a[31] != b[31]) return CanonNan;
            return a;
        end
        if ((b & AbsMask) == InfBits) return b;
        if ((a & AbsMask) == 0 && (b & AbsMask) == 0) return a & b;
        if ((a & AbsMask) == 0) return b;
        if ((b & AbsMask) == 0) return a;
        x = a;
        y = b;
        if ((a & AbsMask) < (b & AbsMask)) begin
            x = b;
            y = a;
        end
        ex = x[30:23];
        ey = y[30:23];
        mx = {8'b0, ex != 0, x[22:0]} << 3;
        my = {8'b0, ey != 0, y[22:0]} << 3;
        if (ex == 0) ex = 1;
        if (ey == 0) ey = 1;
        d = ex - ey;
        if (d >= 30) begin
            my = {31'b0, my != 0};
        end else begin
            my = (my >> d) | {31'b0, (my & ((32'd1 << d) - 1)) != 0};
        end
        m = (x[31] == y[31]) ? mx + my : mx - my;
        if (m == 0) return 32'h0;
        e = ex;
        if (m[27]) begin
            m = (m >> 1) | {31'b0, m[0]};
            e++;
        end else begin
            while (!m[26] && e > 1) begin
                m = m << 1;
                e--;
            end
        end
        if (e >= 255) return {x[31], 8'hFF, 23'b0};
        ef = m[26] ? e : 0;
        up = m[2] & (m[1] | m[0] | m[3]);
        // A carry out of the mantissa moves into the exponent on its own.
        r = (32'(ef) << 23) + {9'b0, m[25:3]} + {31'b0, up};
        return {x[31], r[30:0]};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            running_sum <= 32'h0;
            fail_count  <= 0;
            sum_queue.delete();
        end else begin
            if (s_valid && s_ready) begin
                logic [31:0] next_sum;
                next_sum = fp32_add(running_sum, scaled_term(s_act_bits, s_weight_code));
                if (s_last) begin
                    sum_queue.push_back(next_sum);
                    running_sum <= 32'h0;
                end else begin
                    running_sum <= next_sum;
                end
            end
            if (m_valid && m_ready) begin
                if (sum_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_dot_sum);
                    fail_count <= fail_count + 1;
                end else begin
                    logic [31:0] want;
                    want = sum_queue.pop_front();
                    if (want !== m_dot_sum) begin
                        $display("%0t: dot_sum mismatch, expected %h, actual %h",
                                 $time, want, m_dot_sum);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

    assign pending = sum_queue.size();

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives activation and weight transfers into the dot product unit with
// random idling on both sides, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import pwdp_pkg::*;

    localparam int RandomItems = 1300;
    localparam int CycleLimit  = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_act_bits = '0;
    logic [7:0]  s_weight_code = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_dot_sum;
    int          fail_count;
    int          pending;

    // Idling is switched off for the closing stretch of the run.
    logic        idle_on = 1'b1;
    // Set by the stimulus to ask the receiver for one long hold-off.
    logic        hold_request = 1'b0;
    int          cycle_count = 0;

    always #5 aclk = ~aclk;

    pot_weight_dot_product_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_act_bits    (s_act_bits),
        .s_weight_code (s_weight_code),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dot_sum     (m_dot_sum)
    );

    pwdp_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_act_bits    (s_act_bits),
        .s_weight_code (s_weight_code),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dot_sum     (m_dot_sum),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // A run that hangs is stopped here and counted as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls in random bursts, and once for a long stretch so
    // that the unit fills up and has to stall its input.
    initial begin
        int burst;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                burst = $urandom_range(1, 8);
                repeat (burst) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                burst = $urandom_range(1, 12);
                repeat (burst) @(posedge aclk);
            end
        end
    end

    // Moves one item across the input channel. Valid is left high after the
    // transfer so that back-to-back items need no second assignment.
    task automatic send_pair(logic [31:0] act, logic [7:0] code, logic fin);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_act_bits    <= act;
        s_weight_code <= code;
        s_last        <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Activations weighted towards finite values of moderate size, with the
    // special encodings mixed in.
    function automatic logic [31:0] pick_activation();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return {$urandom_range(0, 1) == 1, 8'hFF, 23'b0};
            2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            4: return {$urandom_range(0, 1) == 1, 31'b0};
            5: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 20)), 23'($urandom)};
            default:
                return {$urandom_range(0, 1) == 1, 8'($urandom_range(110, 145)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 8'($urandom_range(32, 40));
            default: return 8'($urandom_range(0, 8) - 4);
        endcase
    endfunction

    initial begin
        int count;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: field extremes, both weight signs, infinities, NaNs,
        // subnormals, exponent wrap and a cancelling sum.
        send_pair(32'h3F80_0000, 8'h00, 1'b1);
        send_pair(32'h3F80_0000, 8'h1F, 1'b0);
        send_pair(32'h3F80_0000, 8'h20, 1'b1);
        send_pair(32'h4000_0000, 8'h21, 1'b0);
        send_pair(32'h4000_0000, 8'hFF, 1'b1);
        send_pair(InfBits, 8'h03, 1'b1);
        send_pair(InfBits | SignMask, 8'h25, 1'b1);
        send_pair(InfBits, 8'h00, 1'b0);
        send_pair(InfBits | SignMask, 8'h00, 1'b1);
        send_pair(32'h7FC0_1234, 8'h05, 1'b1);
        send_pair(32'hFF80_0001, 8'h80, 1'b1);
        send_pair(32'h0000_0001, 8'h00, 1'b0);
        send_pair(32'h807F_FFFF, 8'h02, 1'b1);
        send_pair(32'h7F7F_FFFF, 8'h01, 1'b1);
        send_pair(32'h7F7F_FFFF, 8'h00, 1'b0);
        send_pair(32'h7F7F_FFFF, 8'h00, 1'b1);
        send_pair(32'h0080_0000, 8'hFF, 1'b1);
        send_pair(32'h3F80_0000, 8'h7F, 1'b1);
        send_pair(32'h3FC0_0000, 8'h00, 1'b0);
        send_pair(32'h3FC0_0000, 8'h20, 1'b1);
        send_pair(32'hFFFF_FFFF, 8'hAA, 1'b0);
        send_pair(32'h0000_0000, 8'h55, 1'b1);

        // Sender pause until every expected sum has been seen. The pending count
        // is read only after the checker has logged the final transfer.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        for (count = 0; count < RandomItems; count++) begin
            if (count == 300) begin
                hold_request <= 1'b1;
            end
            if (count == RandomItems - 150) begin
                idle_on <= 1'b0;
            end
            send_pair(pick_activation(), pick_code(),
                      count == RandomItems - 1 || $urandom_range(0, 5) == 0);
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ pot_weight_dot_product_unit.f @@
sv/pwdp_pkg.sv
sv/pwdp_fadd.sv
sv/pot_weight_dot_product_unit.sv
bench/pwdp_checker.sv
bench/tb_top.sv
